/* rtl/elh_pkg.sv */
// ----------------------------------------------------------------------------
// elh_pkg: shared types and constants for the event counter histogram
// Event kind codes, payload structs for both channels and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package elh_pkg;

  // Number of log2 latency buckets
  localparam int unsigned HIST_BUCKETS = 16;
  // Fixed counters ahead of the buckets: blocked, forwarded, timeouts, sum
  localparam int unsigned FIXED_SLOTS = 4;
  // Largest latency bit length that maps to the lowest bucket
  localparam int unsigned BUCKET_OFFSET = 7;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned KIND_W = 2;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_BLOCKED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FORWARDED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SNAPSHOT  = 2'd3;

  // Fixed slot indexes
  localparam int unsigned SLOT_BLOCKED   = 0;
  localparam int unsigned SLOT_FORWARDED = 1;
  localparam int unsigned SLOT_TIMEOUT   = 2;
  localparam int unsigned SLOT_LAT_SUM   = 3;

  // Input beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CNT_W-1:0]  lat_usec;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  delta;
    logic              last;
  } out_t;

  // Control shared by every cell of the chain
  typedef struct packed {
    logic snap;   // capture count into the shift stage, restart count
    logic shift;  // move the shift stage one cell toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/elh_bucket.sv */
// ----------------------------------------------------------------------------
// elh_bucket: log2 latency bucket index
// Bit length of the latency (bit 0 forced set), minus the offset, clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module elh_bucket
  import elh_pkg::*;
#(
  parameter int unsigned HistBuckets = HIST_BUCKETS,
  localparam int unsigned IdxW = $clog2(HistBuckets)
) (
  input  wire logic [CNT_W-1:0] latency_i,
  output logic      [IdxW-1:0]  bucket_o
);

  localparam int unsigned LenW = $clog2(CNT_W + 1);

  logic [CNT_W-1:0] lat_or1;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  len_off;

  assign lat_or1 = latency_i | CNT_W'(1);

  // Priority encode the highest set bit
  always_comb begin
    len = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (lat_or1[i]) begin
        len = LenW'(i + 1);
      end
    end
  end

  // Offset and clamp into the bucket range
  assign len_off = len - LenW'(BUCKET_OFFSET);

  always_comb begin
    if (len <= LenW'(BUCKET_OFFSET)) begin
      bucket_o = '0;
    end else if (len_off > LenW'(HistBuckets - 1)) begin
      bucket_o = IdxW'(HistBuckets - 1);
    end else begin
      bucket_o = len_off[IdxW-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/elh_cell.sv */
// ----------------------------------------------------------------------------
// elh_cell: one counter cell of the snapshot chain
// Counts since the last snapshot; on a snapshot the count moves into a shift
// stage that drains toward the head of the chain one cell per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module elh_cell
  import elh_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic             inc_en_i,
  input  wire logic [CNT_W-1:0] inc_val_i,
  input  wire logic [CNT_W-1:0] shift_i,
  output logic      [CNT_W-1:0] shift_o
);

  logic [CNT_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] shreg_q, shreg_d;

  // Running count since last snapshot, wraps mod 2^32
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.snap) begin
      acc_d = '0;
    end else if (inc_en_i) begin
      acc_d = acc_q + inc_val_i;
    end
  end

  // Shift stage: capture on snapshot, move on each output beat
  always_comb begin
    shreg_d = shreg_q;
    if (ctrl_i.snap) begin
      shreg_d = acc_q;
    end else if (ctrl_i.shift) begin
      shreg_d = shift_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      shreg_q <= '0;
    end else begin
      acc_q   <= acc_d;
      shreg_q <= shreg_d;
    end
  end

  assign shift_o = shreg_q;

endmodule

`default_nettype wire

/* rtl/event_counters_latency_histogram.sv */
// Run: the first delta beat is offered in the cycle after the snapshot beat
//   is accepted; 4 + HistBuckets beats follow, one per cycle unless stalled.
// Throughput: counting events are taken one per cycle, also during a run; a
//   snapshot waits while the previous run drains through the cell chain.
// Reset: asynchronous, clears every counter and the snapshot baseline at once.
// ----------------------------------------------------------------------------
// event_counters_latency_histogram: event counters with log2 latency histogram
// A chain of counter cells; a snapshot drains per-counter deltas as beats.
// ----------------------------------------------------------------------------
`default_nettype none

module event_counters_latency_histogram
  import elh_pkg::*;
#(
  parameter int unsigned HistBuckets = HIST_BUCKETS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned NumSlots = FIXED_SLOTS + HistBuckets;
  localparam int unsigned IdxW = $clog2(HistBuckets);

  logic             in_acc;
  logic             out_acc;
  logic             is_snap;
  logic             is_fwd;
  logic [IdxW-1:0]  bucket;
  cell_ctrl_t       ctrl;
  logic             busy_q;
  logic [SLOT_W-1:0] slot_q;
  logic             last_beat;

  logic [NumSlots-1:0]            inc_en;
  logic [NumSlots-1:0][CNT_W-1:0] inc_val;
  logic [NumSlots:0][CNT_W-1:0]   chain;

  // Handshakes: a second snapshot waits for the running drain
  assign is_snap    = in_data_i.kind == KIND_SNAPSHOT;
  assign is_fwd     = in_data_i.kind == KIND_FORWARDED;
  assign in_stall_o = busy_q && is_snap;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign last_beat  = slot_q == SLOT_W'(NumSlots - 1);

  assign ctrl.snap  = in_acc && is_snap;
  assign ctrl.shift = out_acc;

  elh_bucket #(
    .HistBuckets(HistBuckets)
  ) u_bucket (
    .latency_i(in_data_i.lat_usec),
    .bucket_o (bucket)
  );

  // Per-cell increment selects
  always_comb begin
    inc_en  = '0;
    inc_val = '0;
    for (int i = 0; i < NumSlots; i++) begin
      inc_val[i] = CNT_W'(1);
    end
    inc_en[SLOT_BLOCKED]   = in_acc && (in_data_i.kind == KIND_BLOCKED);
    inc_en[SLOT_TIMEOUT]   = in_acc && (in_data_i.kind == KIND_TIMEOUT);
    inc_en[SLOT_FORWARDED] = in_acc && is_fwd;
    inc_en[SLOT_LAT_SUM]   = in_acc && is_fwd;
    inc_val[SLOT_LAT_SUM]  = in_data_i.lat_usec;
    for (int b = 0; b < HistBuckets; b++) begin
      inc_en[FIXED_SLOTS + b] = in_acc && is_fwd && (bucket == IdxW'(b));
    end
  end

  // Cell chain, draining toward cell 0
  assign chain[NumSlots] = '0;

  for (genvar g = 0; g < NumSlots; g++) begin : g_cell
    elh_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .inc_en_i (inc_en[g]),
      .inc_val_i(inc_val[g]),
      .shift_i  (chain[g+1]),
      .shift_o  (chain[g])
    );
  end

  // Drain run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
    end else if (ctrl.snap) begin
      busy_q <= 1'b1;
      slot_q <= '0;
    end else if (out_acc) begin
      if (last_beat) begin
        busy_q <= 1'b0;
      end
      slot_q <= slot_q + SLOT_W'(1);
    end
  end

  assign out_valid_o      = busy_q;
  assign out_data_o.slot  = slot_q;
  assign out_data_o.delta = chain[0];
  assign out_data_o.last  = last_beat;

  // Checks
  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slot_q <= SLOT_W'(NumSlots - 1))
    else $error("slot beyond last counter");

  a_run_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.snap |=> out_valid_o && slot_q == '0)
    else $error("snapshot run did not start at slot 0");

  a_run_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.last |=> !out_valid_o)
    else $error("run continued past last beat");

  a_stall_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no run draining");

endmodule

`default_nettype wire
